@@ design/assert_macros.svh @@
// assertion macros shared by the key/value table rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define KVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define KVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/kvt_pkg.sv @@
// package for the key/value table: sizes, request and status codes,
// and the command and status structs between controller and datapath; no dependencies
package kvt_pkg;

  localparam int CAPACITY      = 16;
  localparam int KEY_W         = 16;
  localparam int VALUE_W       = 32;
  localparam int ENTRY_COUNT_W = 5;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef logic [KEY_W-1:0]          key_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [ENTRY_COUNT_W-1:0]  entry_count_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    key_t   key;
    value_t value;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    req_load;
    logic    rd_en;
    addr_t   rd_addr;
    logic    wr_en;
    addr_t   wr_addr;
    logic    wr_from_rd;
    logic    out_load;
    logic    out_found;
    logic    out_hit;
    status_e out_status;
    cnt_t    out_count;
  } kvt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic key_match;
  } kvt_sts_t;

endpackage

@@ design/kvt_req_if.sv @@
// request channel of the key/value table
// depends on kvt_pkg
interface kvt_req_if;
  import kvt_pkg::*;

  logic   valid;
  logic   ready;
  req_e   req_type;
  key_t   key;
  value_t value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

@@ design/kvt_rsp_if.sv @@
// result channel of the key/value table
// depends on kvt_pkg
interface kvt_rsp_if;
  import kvt_pkg::*;

  logic         valid;
  logic         ready;
  logic         found;
  value_t       read_value;
  status_e      status;
  entry_count_t entry_count;
  logic         is_empty;
  logic         is_full;

  modport source (output valid, found, read_value, status, entry_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, found, read_value, status, entry_count, is_empty, is_full,
                  output ready);
endinterface

@@ design/kvt_cfg_if.sv @@
// configuration write channel of the key/value table (miss value)
// depends on kvt_pkg
interface kvt_cfg_if;
  import kvt_pkg::*;

  logic   valid;
  logic   ready;
  value_t miss_value;

  modport source (output valid, miss_value, input ready);
  modport sink   (input valid, miss_value, output ready);
endinterface

@@ design/kvt_dpath.sv @@
// datapath of the key/value table: entry memory, request latch,
// key compare, miss value register and result register; depends on kvt_pkg
module kvt_dpath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  kvt_pkg::value_t        cfg_miss_value_i,
  input  kvt_pkg::key_t          req_key_i,
  input  kvt_pkg::value_t        req_value_i,
  input  kvt_pkg::kvt_cmd_t      cmd_i,
  output kvt_pkg::kvt_sts_t      sts_o,
  output logic                   found_o,
  output kvt_pkg::value_t        read_value_o,
  output kvt_pkg::status_e       status_o,
  output kvt_pkg::entry_count_t  entry_count_o,
  output logic                   is_empty_o,
  output logic                   is_full_o
);
  import kvt_pkg::*;

  entry_t       mem_q [CAPACITY];
  entry_t       rd_q;
  entry_t       wr_data;
  key_t         key_q;
  value_t       value_q;
  value_t       miss_q;
  logic         found_q;
  value_t       read_value_q;
  status_e      status_q;
  entry_count_t entry_count_q;
  logic         is_empty_q;
  logic         is_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= '0;
    end else if (cfg_valid_i) begin
      miss_q <= cfg_miss_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      key_q   <= req_key_i;
      value_q <= req_value_i;
    end
  end

  assign wr_data = cmd_i.wr_from_rd ? rd_q : entry_t'{key: key_q, value: value_q};

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_addr];
    end
  end

  assign sts_o.key_match = (rd_q.key == key_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_q       <= cmd_i.out_found;
      read_value_q  <= cmd_i.out_hit ? rd_q.value : miss_q;
      status_q      <= cmd_i.out_status;
      entry_count_q <= entry_count_t'(cmd_i.out_count);
      is_empty_q    <= (cmd_i.out_count == '0);
      is_full_q     <= (cmd_i.out_count == CAP_CNT);
    end
  end

  assign found_o       = found_q;
  assign read_value_o  = read_value_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;
  assign is_empty_o    = is_empty_q;
  assign is_full_o     = is_full_q;

endmodule

@@ design/kvt_ctrl.sv @@
// controller of the key/value table: request fsm, scan index, entry count
// and result handshake; depends on kvt_pkg
module kvt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  kvt_pkg::req_e     req_type_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output kvt_pkg::kvt_cmd_t cmd_o,
  input  kvt_pkg::kvt_sts_t sts_i
);
  import kvt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  req_e    op_q, op_d;
  cnt_t    idx_q, idx_d;
  cnt_t    count_q, count_d;
  logic    found_q, found_d;
  logic    hit_q, hit_d;
  status_e status_q, status_d;
  logic    rsp_valid_q, rsp_valid_d;
  cnt_t    idx_m1;
  logic    accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign idx_m1      = cnt_t'(idx_q - 1'b1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    hit_d       = hit_q;
    status_d    = status_q;
    rsp_valid_d = rsp_valid_q;

    cmd_o            = '0;
    cmd_o.rd_addr    = idx_q[ADDR_W-1:0];
    cmd_o.wr_addr    = count_q[ADDR_W-1:0];
    cmd_o.out_found  = found_q;
    cmd_o.out_hit    = hit_q;
    cmd_o.out_status = status_q;
    cmd_o.out_count  = count_q;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.req_load = 1'b1;
          op_d           = req_type_i;
          idx_d          = '0;
          found_d        = 1'b0;
          hit_d          = 1'b0;
          status_d       = ST_DONE;
          if (req_type_i == REQ_CLEAR) begin
            count_d = '0;
            state_d = S_FINISH;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          // key absent
          unique case (op_q)
            REQ_INSERT: begin
              if (count_q == CAP_CNT) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.wr_en = 1'b1;
                count_d     = cnt_t'(count_q + 1'b1);
              end
            end
            default: status_d = ST_ABSENT;
          endcase
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.key_match) begin
          found_d = 1'b1;
          unique case (op_q)
            REQ_LOOKUP: begin
              hit_d   = 1'b1;
              state_d = S_FINISH;
            end
            REQ_INSERT: begin
              status_d = ST_PRESENT;
              state_d  = S_FINISH;
            end
            default: begin
              idx_d   = cnt_t'(idx_q + 1'b1);
              state_d = S_SHIFT_RD;
            end
          endcase
        end else begin
          idx_d   = cnt_t'(idx_q + 1'b1);
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (idx_q == count_q) begin
          count_d = cnt_t'(count_q - 1'b1);
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_addr    = idx_m1[ADDR_W-1:0];
        cmd_o.wr_from_rd = 1'b1;
        idx_d            = cnt_t'(idx_q + 1'b1);
        state_d          = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          rsp_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= REQ_LOOKUP;
      idx_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      status_q    <= ST_DONE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      found_q     <= found_d;
      hit_q       <= hit_d;
      status_q    <= status_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

@@ design/key_value_table.sv @@
// top level of the key/value table: controller plus datapath
// depends on kvt_pkg, kvt_req_if, kvt_rsp_if, kvt_cfg_if, kvt_ctrl, kvt_dpath
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    req_type, key, value
//   rsp_o    out  valid/ready    found, read_value, status, entry_count, is_empty, is_full
//   cfg_i    in   valid/ready    miss_value (ready always high)
//
// all but a clear scan the held entries, a read then a compare each; a delete then moves
//   each later entry down by a read and a write; the one memory read port sets the pace
// one request is in work at a time; the next is taken once the result sits
//   in the output register, even while it waits to be taken
// reset clears the entry count and the miss value; entries need no clearing
// a stalled result holds the next request in its finishing step until it is taken
`include "assert_macros.svh"

module key_value_table (
  input logic      clk_i,
  input logic      rst_ni,
  kvt_req_if.sink  req_i,
  kvt_rsp_if.source rsp_o,
  kvt_cfg_if.sink  cfg_i
);
  import kvt_pkg::*;

  kvt_cmd_t cmd;
  kvt_sts_t sts;

  // miss value register takes every write at once
  assign cfg_i.ready = 1'b1;

  // fsm: scan, insert, delete compaction, clear and result handshake
  kvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_type_i  (req_i.req_type),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // entry memory, compare and result register
  kvt_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_miss_value_i (cfg_i.miss_value),
    .req_key_i        (req_i.key),
    .req_value_i      (req_i.value),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .found_o          (rsp_o.found),
    .read_value_o     (rsp_o.read_value),
    .status_o         (rsp_o.status),
    .entry_count_o    (rsp_o.entry_count),
    .is_empty_o       (rsp_o.is_empty),
    .is_full_o        (rsp_o.is_full)
  );

  // an accepted request keeps the block busy: ready is low once the request is taken
  `KVT_ASSERT(a_busy_after_req, (req_i.valid && req_i.ready) |=> !req_i.ready, "request taken while busy")
  // the memory port never reads and writes in the same cycle
  `KVT_ASSERT(a_no_rd_wr, cmd.wr_en |-> !cmd.rd_en, "memory read and write collide")
  // a present key is always reported as found
  `KVT_ASSERT(a_present_found, (rsp_o.valid && rsp_o.status == ST_PRESENT) |-> rsp_o.found, "present key not flagged found")
  // a result is loaded only when the output register is free or being emptied
  `KVT_ASSERT(a_no_overwrite, (rsp_o.valid && !rsp_o.ready) |-> !cmd.out_load, "pending result overwritten")

endmodule

@@ dv/key_value_table_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for key_value_table: directed and random table requests
// against a scoreboard that keeps its own copy of the table; needs kvt_pkg and the channel interfaces
import kvt_pkg::*;

typedef struct packed {
  logic         found;
  value_t       read_value;
  status_e      status;
  entry_count_t entry_count;
  logic         is_empty;
  logic         is_full;
} table_result_t;

class kvt_scoreboard;
  key_t          keys[CAPACITY];
  value_t        vals[CAPACITY];
  int unsigned   held = 0;
  value_t        miss = '0;
  table_result_t pending[$];
  int unsigned   errors = 0;
  int unsigned   checked = 0;
  int unsigned   n_hits = 0, n_misses = 0, n_shifts = 0, n_drops = 0, n_clears = 0;
  int unsigned   n_dups = 0, n_full_seen = 0, n_miss_writes = 0;

  function void set_miss(value_t v);
    miss = v;
    n_miss_writes++;
  endfunction

  // apply one accepted request to the table copy and queue its result
  function void note_request(req_e op, key_t k, value_t v);
    table_result_t want;
    int unsigned   slot;
    logic          present;
    slot = held;
    for (int unsigned i = 0; i < held; i++)
      if (slot == held && keys[i] == k) slot = i;
    present          = (slot < held);
    want.found       = present;
    want.read_value  = miss;
    want.status      = ST_DONE;
    case (op)
      REQ_LOOKUP: begin
        if (present) begin
          want.read_value = vals[slot];
          n_hits++;
        end else begin
          want.status = ST_ABSENT;
          n_misses++;
        end
      end
      REQ_INSERT: begin
        if (present) begin
          want.status = ST_PRESENT;
          n_dups++;
        end else if (held >= CAPACITY) begin
          want.status = ST_FULL;
          n_drops++;
        end else begin
          keys[held] = k;
          vals[held] = v;
          held++;
        end
      end
      REQ_DELETE: begin
        if (present) begin
          if (slot + 1 < held) n_shifts++;
          for (int unsigned j = slot + 1; j < held; j++) begin
            keys[j-1] = keys[j];
            vals[j-1] = vals[j];
          end
          held--;
        end else begin
          want.status = ST_ABSENT;
        end
      end
      default: begin
        want.found = 1'b0;
        held       = 0;
        n_clears++;
      end
    endcase
    want.entry_count = entry_count_t'(held);
    want.is_empty    = (held == 0);
    want.is_full     = (held == CAPACITY);
    if (want.is_full) n_full_seen++;
    pending.push_back(want);
  endfunction

  function void check_result(table_result_t got);
    table_result_t want;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result %0d arrived with no request waiting for it", checked);
      return;
    end
    want = pending.pop_front();
    if (got.found !== want.found || got.read_value !== want.read_value ||
        got.status !== want.status || got.entry_count !== want.entry_count ||
        got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d differs: expected found=%0b value=%0d status=%0d count=%0d empty=%0b full=%0b",
                 checked, want.found, want.read_value, want.status, want.entry_count,
                 want.is_empty, want.is_full);
        $display("  got found=%0b value=%0d status=%0d count=%0d empty=%0b full=%0b",
                 got.found, got.read_value, got.status, got.entry_count, got.is_empty, got.is_full);
      end
    end
  endfunction
endclass

module key_value_table_tb;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 100;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  kvt_req_if req_if ();
  kvt_rsp_if rsp_if ();
  kvt_cfg_if cfg_if ();

  key_value_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  kvt_scoreboard sb = new;

  // sender pacing: burst length left and whether this phase runs gap free
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;
  key_t        key_pool[POOL_SIZE];
  int unsigned cycles     = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver stall pattern: switches at random between always ready, coin flip,
  // mostly stalled and mostly ready
  logic        rsp_ready_q = 1'b0;
  int unsigned stall_mode  = 0;
  int unsigned mode_left   = 0;
  assign rsp_if.ready = rsp_ready_q;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: rsp_ready_q <= 1'b1;
      1: rsp_ready_q <= $urandom_range(0, 1);
      2: rsp_ready_q <= ($urandom_range(0, 7) == 0);
      default: rsp_ready_q <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // result monitor: values read here are the ones from before the edge
  always @(posedge clk_i) begin
    if (rst_n && rsp_if.valid === 1'b1 && rsp_ready_q)
      sb.check_result({rsp_if.found, rsp_if.read_value, rsp_if.status,
                       rsp_if.entry_count, rsp_if.is_empty, rsp_if.is_full});
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.pending.size());
      $display("key_value_table: mismatch");
      $finish;
    end
  end

  // one request; valid stays up into the next request unless a gap is due
  task automatic send_req(req_e op, key_t k, value_t v);
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.key      <= k;
    req_if.value    <= v;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(op, k, v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // miss value write, only while the table is idle
  task automatic write_miss(value_t v);
    cfg_if.valid      <= 1'b1;
    cfg_if.miss_value <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.set_miss(v);
    cfg_if.valid <= 1'b0;
  endtask

  // stop sending and let every owed result come back, then a short settle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // random request; keys favor held entries and a small pool so hits,
  // duplicates and a full table come up often
  task automatic send_random(int unsigned insert_pct);
    int unsigned pick;
    int unsigned src;
    req_e        op;
    key_t        k;
    pick = $urandom_range(0, 99);
    if (pick < 3)                                   op = REQ_CLEAR;
    else if (pick < 3 + insert_pct)                 op = REQ_INSERT;
    else if (pick < 3 + insert_pct + (97 - insert_pct) / 2) op = REQ_LOOKUP;
    else                                            op = REQ_DELETE;
    src = $urandom_range(0, 99);
    if (src < 45 && sb.held > 0) k = sb.keys[$urandom_range(0, sb.held - 1)];
    else if (src < 85)           k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else                         k = key_t'($urandom);
    send_req(op, k, value_t'($urandom));
  endtask

  initial begin
    int unsigned insert_mix[PHASES] = '{60, 25, 45, 70, 20, 40};
    value_t      phase_miss;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_LOOKUP;
    req_if.key        <= '0;
    req_if.value      <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.miss_value <= '0;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, filling to capacity, requests on a full table,
    // deletes at the front, middle and end, and a clear
    steady = 1'b1;
    write_miss(32'sh8000_0000);
    send_req(REQ_LOOKUP, 16'h0000, '0);
    send_req(REQ_DELETE, 16'hFFFF, '0);
    send_req(REQ_CLEAR, 16'hFFFF, 32'shFFFF_FFFF);
    send_req(REQ_INSERT, 16'h0000, 32'sh8000_0000);
    send_req(REQ_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
    for (int i = 0; i < CAPACITY - 2; i++)
      send_req(REQ_INSERT, key_t'(16'h0101 * (i + 1)), value_t'($urandom));
    send_req(REQ_INSERT, 16'h1234, 32'sh1234_5678);   // table full, dropped
    send_req(REQ_INSERT, 16'h0000, 32'sh5555_5555);   // present while full
    send_req(REQ_LOOKUP, 16'hFFFF, '0);
    send_req(REQ_LOOKUP, 16'h1234, '0);               // miss value shows
    send_req(REQ_DELETE, 16'h0707, '0);               // middle, later entries shift
    send_req(REQ_DELETE, 16'h0000, '0);               // front
    send_req(REQ_DELETE, 16'h0E0E, '0);               // last, nothing to shift
    send_req(REQ_DELETE, 16'h0707, '0);               // already gone
    send_req(REQ_LOOKUP, 16'h0808, '0);               // moved entry still found
    send_req(REQ_CLEAR, 16'h5A5A, 32'sh0F0F_0F0F);
    drain();

    // random phases, each with its own miss value, insert mix and key pool
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_miss = 32'sh7FFF_FFFF;
        1:       phase_miss = 32'shFFFF_FFFF;
        2:       phase_miss = '0;
        4:       phase_miss = 32'sh8000_0000;
        default: phase_miss = value_t'($urandom);
      endcase
      write_miss(phase_miss);
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom);
      steady     = (p == 2);
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(insert_mix[p]);
      drain();
    end

    $display("requests: %0d lookup hits, %0d misses, %0d duplicate inserts, %0d dropped when full",
             sb.n_hits, sb.n_misses, sb.n_dups, sb.n_drops);
    $display("%0d deletes with compaction, %0d clears, %0d full-table results, %0d miss writes",
             sb.n_shifts, sb.n_clears, sb.n_full_seen, sb.n_miss_writes);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("key_value_table: match");
    end else begin
      $display("%0d bad results, %0d results never seen", sb.errors, sb.pending.size());
      $display("key_value_table: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/kvt_pkg.sv
design/kvt_req_if.sv
design/kvt_rsp_if.sv
design/kvt_cfg_if.sv
design/kvt_dpath.sv
design/kvt_ctrl.sv
design/key_value_table.sv
dv/key_value_table_tb.sv
